@@ rtl/fpts_pkg.sv @@
// shared constants, codes and types of the fixed-priority task scheduler
`default_nettype none
package fpts_pkg;

   // default sizing
   localparam int DEF_NUM_TASKS     = 8;
   localparam int DEF_PRIORITY_BITS = 8;

   // fixed widths of the transaction fields
   localparam int ACTION_W  = 2;
   localparam int INDEX_W   = 3;
   localparam int IN_PRIO_W = 8;
   localparam int STATUS_W  = 3;
   localparam int RESULT_W  = 3;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_REGISTER  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ACTIVATE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DISPATCH  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_TERMINATE = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD_SLOT = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_SUSP = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_BUSY     = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_IDLE     = 3'd5;

   // control of the shared priority compare unit
   typedef struct packed {
      logic start;       // clear the running best
      logic step;        // one candidate is presented
      logic cand_ready;  // the candidate slot is ready
   } cmp_ctrl_type;

endpackage
`default_nettype wire

@@ rtl/fixed_priority_task_scheduler_core.sv @@
// top level: task table, command sequencer and response register
// response: register, activate, terminate and a refused dispatch answer in the cycle after acceptance
// dispatch: the scan reads the registered slots in order, one slot a cycle, then answers after the last compare
// throughput: one transaction at a time; req_ready returns once the response is taken
// reset: synchronous active high; clears slot count, ready bits, running task, response valid
//   and sets the scheduler enable; the priority memory is not cleared
`default_nettype none
module fixed_priority_task_scheduler_core #(
   parameter int NUM_TASKS     = fpts_pkg::DEF_NUM_TASKS,
   parameter int PRIORITY_BITS = fpts_pkg::DEF_PRIORITY_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // command channel
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [fpts_pkg::ACTION_W-1:0]   req_action,
   input  wire logic [fpts_pkg::INDEX_W-1:0]    req_task_index,
   input  wire logic [fpts_pkg::IN_PRIO_W-1:0]  req_task_priority,
   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [fpts_pkg::STATUS_W-1:0]   rsp_status,
   output logic      [fpts_pkg::RESULT_W-1:0]   rsp_result_task,
   // scheduler enable register
   input  wire logic                            csr_wr_en,
   input  wire logic                            csr_wr_data
);

   localparam int SLOT_W = $clog2(NUM_TASKS);
   localparam int CNT_W  = $clog2(NUM_TASKS + 1);
   localparam int CMP_W  = (CNT_W > fpts_pkg::INDEX_W) ? CNT_W : fpts_pkg::INDEX_W;

   // sequencer states
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic state_ff, state_in;

   // task table control state
   logic                 enabled_ff;
   logic [CNT_W-1:0]     used_ff, used_in;
   logic [NUM_TASKS-1:0] ready_ff, ready_in;     // one bit per slot, set means ready
   logic                 run_valid_ff, run_valid_in;
   logic [SLOT_W-1:0]    run_slot_ff, run_slot_in;

   // scan pipeline
   logic [CNT_W-1:0]  addr_ff, addr_in;          // next slot to read
   logic              pend_ff, pend_in;          // read data arrives this cycle
   logic [SLOT_W-1:0] rd_idx_ff, rd_idx_in;      // slot of the arriving read data

   // response register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [fpts_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [fpts_pkg::RESULT_W-1:0]   rsp_task_ff, rsp_task_in;

   // memory and compare unit hookup
   logic                     mem_we;
   logic [SLOT_W-1:0]        mem_waddr;
   logic [PRIORITY_BITS-1:0] mem_wdata;
   logic [PRIORITY_BITS-1:0] mem_rdata;
   fpts_pkg::cmp_ctrl_type   cmp_ctrl;
   logic                     cmp_found;
   logic [SLOT_W-1:0]        cmp_best;

   logic accept;
   logic issue;

   // resized views of the request fields
   logic [PRIORITY_BITS+fpts_pkg::IN_PRIO_W-1:0] prio_wide;
   logic [SLOT_W+fpts_pkg::INDEX_W-1:0]          idx_wide;
   logic [SLOT_W-1:0]                            act_slot;
   logic [CMP_W-1:0]                             idx_cmp;
   logic [CMP_W-1:0]                             used_cmp;
   logic [SLOT_W+fpts_pkg::RESULT_W-1:0]         used_task_wide;
   logic [SLOT_W+fpts_pkg::RESULT_W-1:0]         best_task_wide;

   assign prio_wide      = {PRIORITY_BITS'(0), req_task_priority};
   assign idx_wide       = {SLOT_W'(0), req_task_index};
   assign act_slot       = idx_wide[SLOT_W-1:0];
   assign idx_cmp        = CMP_W'(req_task_index);
   assign used_cmp       = CMP_W'(used_ff);
   assign used_task_wide = {fpts_pkg::RESULT_W'(0), used_ff[SLOT_W-1:0]};
   assign best_task_wide = {fpts_pkg::RESULT_W'(0), cmp_best};

   // one transaction in flight; a new command waits for the response to drain
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;

   // a new slot is written at the current fill count
   assign mem_waddr = used_ff[SLOT_W-1:0];
   assign mem_wdata = prio_wide[PRIORITY_BITS-1:0];

   // scan keeps reading while registered slots remain
   assign issue = (state_ff == ST_SCAN) && (addr_ff < used_ff);

   fpts_prio_mem #(
      .DEPTH  (NUM_TASKS),
      .WIDTH  (PRIORITY_BITS),
      .ADDR_W (SLOT_W)
   ) u_prio_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (addr_ff[SLOT_W-1:0]),
      .rd_data (mem_rdata)
   );

   fpts_best_cmp #(
      .IDX_W  (SLOT_W),
      .PRIO_W (PRIORITY_BITS)
   ) u_best_cmp (
      .clock     (clock),
      .ctrl      (cmp_ctrl),
      .cand_prio (mem_rdata),
      .cand_idx  (rd_idx_ff),
      .found     (cmp_found),
      .best_idx  (cmp_best)
   );

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      ready_in      = ready_ff;
      run_valid_in  = run_valid_ff;
      run_slot_in   = run_slot_ff;
      addr_in       = addr_ff;
      pend_in       = 1'b0;
      rd_idx_in     = addr_ff[SLOT_W-1:0];
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_task_in   = rsp_task_ff;
      mem_we        = 1'b0;
      cmp_ctrl.start      = 1'b0;
      cmp_ctrl.step       = pend_ff;
      cmp_ctrl.cand_ready = ready_ff[rd_idx_ff];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // register, activate, terminate and a refused dispatch answer right away; only dispatch scans
               rsp_valid_in  = 1'b1;
               rsp_status_in = fpts_pkg::STAT_OK;
               rsp_task_in   = '0;
               unique case (req_action)
                  fpts_pkg::ACT_REGISTER: begin
                     if (used_ff == CNT_W'(NUM_TASKS)) begin
                        rsp_status_in = fpts_pkg::STAT_FULL;
                     end else begin
                        // a fresh slot is never ready nor running, so it starts suspended
                        mem_we      = 1'b1;
                        used_in     = used_ff + CNT_W'(1);
                        rsp_task_in = used_task_wide[fpts_pkg::RESULT_W-1:0];
                     end
                  end
                  fpts_pkg::ACT_ACTIVATE: begin
                     if (idx_cmp >= used_cmp) begin
                        rsp_status_in = fpts_pkg::STAT_BAD_SLOT;
                     end else if (ready_ff[act_slot] ||
                                  (run_valid_ff && (run_slot_ff == act_slot))) begin
                        rsp_status_in = fpts_pkg::STAT_NOT_SUSP;
                     end else begin
                        ready_in[act_slot] = 1'b1;
                     end
                  end
                  fpts_pkg::ACT_DISPATCH: begin
                     if (!enabled_ff) begin
                        rsp_status_in = fpts_pkg::STAT_IDLE;
                     end else if (run_valid_ff) begin
                        rsp_status_in = fpts_pkg::STAT_BUSY;
                     end else begin
                        // hold the response until the scan finishes
                        rsp_valid_in   = 1'b0;
                        state_in       = ST_SCAN;
                        addr_in        = '0;
                        cmp_ctrl.start = 1'b1;
                     end
                  end
                  fpts_pkg::ACT_TERMINATE: begin
                     // the running slot drops back to suspended; no-op if none runs
                     run_valid_in = 1'b0;
                  end
                  default: begin
                     rsp_status_in = fpts_pkg::STAT_OK;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // one slot read per cycle, compared in the next cycle
            if (issue) begin
               addr_in = addr_ff + CNT_W'(1);
               pend_in = 1'b1;
            end
            if (!issue && !pend_ff) begin
               // last candidate already folded into the compare unit
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (cmp_found) begin
                  rsp_status_in      = fpts_pkg::STAT_OK;
                  rsp_task_in        = best_task_wide[fpts_pkg::RESULT_W-1:0];
                  run_valid_in       = 1'b1;
                  run_slot_in        = cmp_best;
                  ready_in[cmp_best] = 1'b0;
               end else begin
                  rsp_status_in = fpts_pkg::STAT_IDLE;
                  rsp_task_in   = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enabled_ff   <= 1'b1;
         used_ff      <= '0;
         ready_ff     <= '0;
         run_valid_ff <= 1'b0;
         run_slot_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         ready_ff     <= ready_in;
         run_valid_ff <= run_valid_in;
         run_slot_ff  <= run_slot_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            enabled_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      rd_idx_ff     <= rd_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_task_ff   <= rsp_task_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_task = rsp_task_ff;

endmodule
`default_nettype wire

@@ rtl/fpts_prio_mem.sv @@
// priority table memory, one write port and one registered read port
`default_nettype none
module fpts_prio_mem #(
   parameter int DEPTH  = fpts_pkg::DEF_NUM_TASKS,
   parameter int WIDTH  = fpts_pkg::DEF_PRIORITY_BITS,
   parameter int ADDR_W = $clog2(fpts_pkg::DEF_NUM_TASKS)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/fpts_best_cmp.sv @@
// shared compare unit that keeps the best ready slot seen during a scan
`default_nettype none
module fpts_best_cmp #(
   parameter int IDX_W  = $clog2(fpts_pkg::DEF_NUM_TASKS),
   parameter int PRIO_W = fpts_pkg::DEF_PRIORITY_BITS
) (
   input  wire logic                  clock,
   input  wire fpts_pkg::cmp_ctrl_type ctrl,
   input  wire logic [PRIO_W-1:0]     cand_prio,
   input  wire logic [IDX_W-1:0]      cand_idx,
   output logic                       found,
   output logic [IDX_W-1:0]           best_idx
);

   logic              found_ff, found_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [PRIO_W-1:0] top_prio_ff, top_prio_in;

   // strict greater keeps the lowest slot on a tie
   always_comb begin
      found_in    = found_ff;
      best_idx_in = best_idx_ff;
      top_prio_in = top_prio_ff;
      priority if (ctrl.start) begin
         found_in = 1'b0;
      end else if (ctrl.step && ctrl.cand_ready &&
                   (!found_ff || (cand_prio > top_prio_ff))) begin
         found_in    = 1'b1;
         best_idx_in = cand_idx;
         top_prio_in = cand_prio;
      end
   end

   always_ff @(posedge clock) begin
      found_ff    <= found_in;
      best_idx_ff <= best_idx_in;
      top_prio_ff <= top_prio_in;
   end

   assign found    = found_ff;
   assign best_idx = best_idx_ff;

endmodule
`default_nettype wire

@@ rtl/fpts_checker.sv @@
// port-level checker for the scheduler core and its bind
`default_nettype none
module fpts_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [fpts_pkg::STATUS_W-1:0]   rsp_status,
   input wire logic [fpts_pkg::RESULT_W-1:0]   rsp_result_task
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                  $stable(rsp_result_task))
      else $error("response changed while stalled");

   // only one transaction in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command accepted while another is in flight");

   // failing commands report slot zero
   a_err_task_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != fpts_pkg::STAT_OK) |-> rsp_result_task == '0)
      else $error("nonzero slot with an error status");

   // no status code beyond idle
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= fpts_pkg::STAT_IDLE)
      else $error("undefined status code");

   // reset leaves no response pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind fixed_priority_task_scheduler_core fpts_checker u_fpts_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_result_task (rsp_result_task)
);
`default_nettype wire

@@ tb/tb_fixed_priority_task_scheduler_core.sv @@
// testbench for the fixed-priority task scheduler core: directed and random command traffic
`timescale 1ns / 1ps
module tb_fixed_priority_task_scheduler_core;

   localparam int TASK_SLOTS = fpts_pkg::DEF_NUM_TASKS;
   localparam int MAX_REPORTS = 10;

   // life cycle of one task slot as the scoreboard sees it
   typedef enum logic [1:0] {
      MODE_SUSPENDED,
      MODE_READY,
      MODE_RUNNING
   } slot_mode_type;

   // one answer of the scheduler
   typedef struct {
      logic [fpts_pkg::STATUS_W-1:0] status;
      logic [fpts_pkg::RESULT_W-1:0] slot;
   } sched_reply_type;

   // clock, reset and dut ports
   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [fpts_pkg::ACTION_W-1:0]  req_action = fpts_pkg::ACT_REGISTER;
   logic [fpts_pkg::INDEX_W-1:0]   req_task_index = '0;
   logic [fpts_pkg::IN_PRIO_W-1:0] req_task_priority = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [fpts_pkg::STATUS_W-1:0]  rsp_status;
   logic [fpts_pkg::RESULT_W-1:0]  rsp_result_task;
   logic                           csr_wr_en = 1'b0;
   logic                           csr_wr_data = 1'b0;

   // shadow copy of the task table, the running task and the enable bit
   int unsigned                    tbl_count;
   logic [fpts_pkg::IN_PRIO_W-1:0] tbl_prio [TASK_SLOTS];
   slot_mode_type                  tbl_mode [TASK_SLOTS];
   bit                             run_valid;
   logic [fpts_pkg::RESULT_W-1:0]  run_slot;
   bit                             sched_on;

   // answers still owed by the dut, oldest first
   sched_reply_type pending_replies [$];
   int              mismatch_count = 0;

   // when set, neither side inserts idle cycles
   bit steady_flow = 1'b0;

   always #4 clock = ~clock;

   fixed_priority_task_scheduler_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_task_index    (req_task_index),
      .req_task_priority (req_task_priority),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_result_task   (rsp_result_task),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // idle cycles before the next transaction on either side
   function automatic int draw_gap();
      return steady_flow ? 0 : $urandom_range(0, 5);
   endfunction

   // priorities lean toward the extremes so that ties are common
   function automatic logic [fpts_pkg::IN_PRIO_W-1:0] pick_priority();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return fpts_pkg::IN_PRIO_W'($urandom_range(0, 255));
      endcase
   endfunction

   // advance the shadow table by one command and return the answer it owes
   function automatic sched_reply_type apply_command(
         logic [fpts_pkg::ACTION_W-1:0]  act,
         logic [fpts_pkg::INDEX_W-1:0]   idx,
         logic [fpts_pkg::IN_PRIO_W-1:0] prio);
      sched_reply_type                reply;
      bit                             found;
      int unsigned                    best;
      logic [fpts_pkg::IN_PRIO_W-1:0] top_prio;
      reply.status = fpts_pkg::STAT_OK;
      reply.slot   = '0;
      found        = 1'b0;
      best         = 0;
      top_prio     = '0;
      case (act)
         fpts_pkg::ACT_REGISTER: begin
            if (tbl_count >= TASK_SLOTS) begin
               reply.status = fpts_pkg::STAT_FULL;
            end else begin
               tbl_prio[tbl_count] = prio;
               tbl_mode[tbl_count] = MODE_SUSPENDED;
               reply.slot = fpts_pkg::RESULT_W'(tbl_count);
               tbl_count++;
            end
         end
         fpts_pkg::ACT_ACTIVATE: begin
            if (idx >= tbl_count) begin
               reply.status = fpts_pkg::STAT_BAD_SLOT;
            end else if (tbl_mode[idx] != MODE_SUSPENDED) begin
               reply.status = fpts_pkg::STAT_NOT_SUSP;
            end else begin
               tbl_mode[idx] = MODE_READY;
            end
         end
         fpts_pkg::ACT_DISPATCH: begin
            if (!sched_on) begin
               reply.status = fpts_pkg::STAT_IDLE;
            end else if (run_valid) begin
               reply.status = fpts_pkg::STAT_BUSY;
            end else begin
               // strict greater-than keeps the lowest slot on a tie
               for (int i = 0; i < tbl_count; i++) begin
                  if (tbl_mode[i] == MODE_READY &&
                      (!found || tbl_prio[i] > top_prio)) begin
                     found    = 1'b1;
                     best     = i;
                     top_prio = tbl_prio[i];
                  end
               end
               if (!found) begin
                  reply.status = fpts_pkg::STAT_IDLE;
               end else begin
                  tbl_mode[best] = MODE_RUNNING;
                  run_valid      = 1'b1;
                  run_slot       = fpts_pkg::RESULT_W'(best);
                  reply.slot     = fpts_pkg::RESULT_W'(best);
               end
            end
         end
         default: begin
            // terminate with nothing running is a quiet no-op
            if (run_valid) begin
               tbl_mode[run_slot] = MODE_SUSPENDED;
               run_valid          = 1'b0;
            end
         end
      endcase
      return reply;
   endfunction

   // drive one command transaction and record the answer it should produce
   task automatic send_command(input logic [fpts_pkg::ACTION_W-1:0]  act,
                               input logic [fpts_pkg::INDEX_W-1:0]   idx,
                               input logic [fpts_pkg::IN_PRIO_W-1:0] prio);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_action        = act;
      req_task_index    = idx;
      req_task_priority = prio;
      do @(posedge clock); while (!req_ready);
      pending_replies.push_back(apply_command(act, idx, prio));
   endtask

   // drop the command channel and let every owed answer come back
   task automatic wait_for_replies();
      int guard;
      guard = 0;
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_replies.size() != 0 && guard < 400) begin
         @(posedge clock);
         guard++;
      end
   endtask

   // the enable register is only written with the block idle
   task automatic write_enable(input bit value);
      wait_for_replies();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      sched_on    = value;
   endtask

   // empty table: dispatch finds nothing, terminate is a no-op, activate hits bad slots
   task automatic test_empty_table();
      send_command(fpts_pkg::ACT_DISPATCH, 3'd0, 8'h00);
      send_command(fpts_pkg::ACT_TERMINATE, 3'd7, 8'hff);
      send_command(fpts_pkg::ACT_ACTIVATE, 3'd0, 8'h00);
      send_command(fpts_pkg::ACT_ACTIVATE, 3'd7, 8'hff);
   endtask

   // priority order, lowest-slot tie break, busy and not-suspended cases
   task automatic test_priority_order();
      send_command(fpts_pkg::ACT_REGISTER, 3'd5, 8'hff);
      send_command(fpts_pkg::ACT_REGISTER, 3'd2, 8'h00);
      send_command(fpts_pkg::ACT_REGISTER, 3'd0, 8'hff);
      send_command(fpts_pkg::ACT_ACTIVATE, 3'd0, 8'h00);
      send_command(fpts_pkg::ACT_ACTIVATE, 3'd0, 8'h00);
      send_command(fpts_pkg::ACT_ACTIVATE, 3'd1, 8'h55);
      send_command(fpts_pkg::ACT_ACTIVATE, 3'd2, 8'haa);
      send_command(fpts_pkg::ACT_ACTIVATE, 3'd3, 8'h00);
      send_command(fpts_pkg::ACT_DISPATCH, 3'd7, 8'hff);
      send_command(fpts_pkg::ACT_DISPATCH, 3'd0, 8'h00);
      send_command(fpts_pkg::ACT_ACTIVATE, 3'd0, 8'h00);
      send_command(fpts_pkg::ACT_TERMINATE, 3'd0, 8'h00);
      send_command(fpts_pkg::ACT_DISPATCH, 3'd0, 8'h00);
      send_command(fpts_pkg::ACT_TERMINATE, 3'd0, 8'h00);
      send_command(fpts_pkg::ACT_DISPATCH, 3'd0, 8'h00);
      send_command(fpts_pkg::ACT_TERMINATE, 3'd0, 8'h00);
      send_command(fpts_pkg::ACT_DISPATCH, 3'd0, 8'h00);
   endtask

   // with the scheduler shut down a dispatch answers idle even with work ready
   task automatic test_scheduler_off();
      write_enable(1'b0);
      send_command(fpts_pkg::ACT_ACTIVATE, 3'd0, 8'h00);
      send_command(fpts_pkg::ACT_DISPATCH, 3'd0, 8'h00);
      write_enable(1'b1);
      send_command(fpts_pkg::ACT_DISPATCH, 3'd0, 8'h00);
      send_command(fpts_pkg::ACT_TERMINATE, 3'd0, 8'h00);
   endtask

   // mostly well-formed activate/dispatch/terminate traffic, sparse registers,
   // some activates on random slots; the enable bit changes between phases
   task automatic test_random_traffic();
      bit                            phase_enable [7] = '{1'b1, 1'b0, 1'b1, 1'b1,
                                                         1'b0, 1'b1, 1'b1};
      int                            pick;
      logic [fpts_pkg::ACTION_W-1:0] act;
      logic [fpts_pkg::INDEX_W-1:0]  idx;
      foreach (phase_enable[p]) begin
         write_enable(phase_enable[p]);
         steady_flow = ($urandom_range(0, 3) == 0);
         repeat (62) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)       act = fpts_pkg::ACT_REGISTER;
            else if (pick < 45) act = fpts_pkg::ACT_ACTIVATE;
            else if (pick < 75) act = fpts_pkg::ACT_DISPATCH;
            else                act = fpts_pkg::ACT_TERMINATE;
            if (act == fpts_pkg::ACT_ACTIVATE && tbl_count > 0 &&
                $urandom_range(0, 99) < 85)
               idx = fpts_pkg::INDEX_W'($urandom_range(0, tbl_count - 1));
            else
               idx = fpts_pkg::INDEX_W'($urandom_range(0, 7));
            send_command(act, idx, pick_priority());
         end
      end
      steady_flow = 1'b0;
   endtask

   // fill every slot, then registers report a full table; an activate, terminate and dispatch follow
   task automatic test_table_full();
      while (tbl_count < TASK_SLOTS)
         send_command(fpts_pkg::ACT_REGISTER, fpts_pkg::INDEX_W'($urandom_range(0, 7)),
                      pick_priority());
      send_command(fpts_pkg::ACT_REGISTER, 3'd0, 8'hff);
      send_command(fpts_pkg::ACT_REGISTER, 3'd7, 8'h00);
      send_command(fpts_pkg::ACT_ACTIVATE, 3'd7, 8'h00);
      send_command(fpts_pkg::ACT_TERMINATE, 3'd0, 8'h00);
      send_command(fpts_pkg::ACT_DISPATCH, 3'd0, 8'h00);
   endtask

   // response side: random back-pressure, including before a response shows up
   initial begin
      int stall;
      @(negedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // compare each accepted response with the oldest owed answer
   always @(posedge clock) begin
      sched_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected response: status %0d slot %0d",
                        rsp_status, rsp_result_task);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status || rsp_result_task !== want.slot) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"response mismatch: expected status %0d slot %0d, ",
                            "got status %0d slot %0d"},
                           want.status, want.slot, rsp_status, rsp_result_task);
            end
         end
      end
   end

   // main sequence
   initial begin
      tbl_count = 0;
      run_valid = 1'b0;
      run_slot  = '0;
      sched_on  = 1'b1;
      foreach (tbl_mode[i]) begin
         tbl_mode[i] = MODE_SUSPENDED;
         tbl_prio[i] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // enable register written right after reset
      write_enable(1'b1);
      test_empty_table();
      test_priority_order();
      test_scheduler_off();
      test_random_traffic();
      test_table_full();

      // drain, then leave room for a dispatch scan over the whole table
      wait_for_replies();
      repeat (3 * TASK_SLOTS + 10) @(posedge clock);
      if (pending_replies.size() != 0) begin
         mismatch_count++;
         $display("%0d responses never arrived", pending_replies.size());
      end
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #(2_000_000);
      $display("tb: failure");
      $finish;
   end

endmodule
